// ===== src/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the spring-damper force pipeline
// fixed field widths, register codes and reset values
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int COMP_W     = 21;            // one signed vector component
    localparam int FRAC_BITS  = 12;            // default fraction bits
    localparam int VEC_W      = 3 * COMP_W;    // packed x,y,z
    localparam int COEF_W     = 16;            // stiffness, damping, scales
    localparam int REST_W     = 20;            // rest length
    localparam int SLOT_W     = 12;            // particle slot ports
    localparam int SLOT_COUNT = 4096;          // slot space, power of two
    localparam int CFG_IDX_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS_SCALE = 8'd0,
        CFG_AMPLITUDE  = 8'd1
    } t_cfg_idx;

    localparam logic [COEF_W-1:0] MASS_RESET = 16'd4096;  // 1.0
    localparam logic [COEF_W-1:0] AMP_RESET  = 16'd4096;  // 1.0

    // per-spring sideband carried alongside the arithmetic
    typedef struct packed {
        logic [COEF_W-1:0] stiff;
        logic [COEF_W-1:0] damp;
        logic [REST_W-1:0] rest;
        logic              a_pin;
        logic              b_pin;
        logic              zero;
        logic [SLOT_W-1:0] a_slot;
        logic [SLOT_W-1:0] b_slot;
    } t_side;

endpackage

// ===== src/sdf_div.sv =====
// ----------------------------------------------------------------------------
// sdf_div: pipelined restoring divider, several lanes over one divisor
// one quotient bit per stage, sign applied in a final stage (trunc to zero)
// ----------------------------------------------------------------------------
module sdf_div #(
    parameter int N     = 57,   // dividend magnitude width
    parameter int D     = 22,   // divisor width
    parameter int Q     = 35,   // quotient bits, needs dividend < divisor << Q
    parameter int LANES = 4,
    parameter int TAG_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][N-1:0]     i_dividend,
    input  logic [LANES-1:0]            i_neg,
    input  logic [D-1:0]                i_divisor,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_valid,
    output logic [LANES-1:0][Q:0]       o_quot,
    output logic [TAG_W-1:0]            o_tag
);

    logic             r_v   [0:Q];
    logic [D-1:0]     r_dsr [0:Q];
    logic [TAG_W-1:0] r_tag [0:Q];
    logic             r_ov;
    logic [TAG_W-1:0] r_otag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Q; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= Q; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[Q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsr[0] <= i_divisor;
            r_tag[0] <= i_tag;
            for (int k = 1; k <= Q; k++) begin
                r_dsr[k] <= r_dsr[k-1];
                r_tag[k] <= r_tag[k-1];
            end
            r_otag <= r_tag[Q];
        end
    end

    genvar j, k;
    generate
        for (j = 0; j < LANES; j++) begin : g_lane
            logic [D-1:0] r_rem [0:Q];
            logic [Q-1:0] r_low [0:Q];
            logic [Q-1:0] r_quo [0:Q];
            logic         r_neg [0:Q];
            logic [Q:0]   r_res;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[0] <= D'(i_dividend[j] >> Q);
                    r_low[0] <= i_dividend[j][Q-1:0];
                    r_quo[0] <= '0;
                    r_neg[0] <= i_neg[j];
                end
            end

            for (k = 0; k < Q; k++) begin : g_step
                logic [D:0] n_trial;
                logic       n_ge;
                assign n_trial = {r_rem[k], r_low[k][Q-1]};
                assign n_ge    = (n_trial >= {1'b0, r_dsr[k]});
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k+1] <= n_ge ? D'(n_trial - {1'b0, r_dsr[k]}) : D'(n_trial);
                        r_low[k+1] <= {r_low[k][Q-2:0], 1'b0};
                        r_quo[k+1] <= {r_quo[k][Q-2:0], n_ge};
                        r_neg[k+1] <= r_neg[k];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_res <= r_neg[Q] ? ((Q+1)'(0) - {1'b0, r_quo[Q]}) : {1'b0, r_quo[Q]};
                end
            end

            assign o_quot[j] = r_res;
        end
    endgenerate

    assign o_valid = r_ov;
    assign o_tag   = r_otag;

endmodule

// ===== src/spring_damper_force_top.sv =====
// ----------------------------------------------------------------------------
// spring_damper_force_top: spring-damper force, one spring per clock unless stalled
// separation, length, projection and scaled force, saturated Q8.12 output
// ----------------------------------------------------------------------------
// One spring word enters per clock while the output word is not stalled, and
// its force word leaves in input order. The depth is set by the square root,
// one root bit per stage, and by the divider, one quotient bit per stage. The
// pipeline holds a word in each stage and freezes as a whole while the output
// word is stalled, so nothing is dropped or repeated. mass_scale and amplitude
// are written through the config port (always ready) and must only change while
// no word is in flight.
module spring_damper_force_top #(
    parameter int FRAC_BITS = sdf_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input word channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sdf_pkg::VEC_W-1:0]    i_a_position,
    input  logic [sdf_pkg::VEC_W-1:0]    i_a_velocity,
    input  logic [sdf_pkg::VEC_W-1:0]    i_b_position,
    input  logic [sdf_pkg::VEC_W-1:0]    i_b_velocity,
    input  logic                         i_a_pinned,
    input  logic                         i_b_pinned,
    input  logic [sdf_pkg::COEF_W-1:0]   i_stiffness,
    input  logic [sdf_pkg::COEF_W-1:0]   i_damping,
    input  logic [sdf_pkg::REST_W-1:0]   i_rest_length,
    input  logic [sdf_pkg::SLOT_W-1:0]   i_a_index,
    input  logic [sdf_pkg::SLOT_W-1:0]   i_b_index,
    // output word channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sdf_pkg::VEC_W-1:0]    o_force_on_a,
    output logic [sdf_pkg::VEC_W-1:0]    o_force_on_b,
    output logic [sdf_pkg::SLOT_W-1:0]   o_a_slot,
    output logic [sdf_pkg::SLOT_W-1:0]   o_b_slot,
    output logic                         o_zero_length,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdf_pkg::COEF_W-1:0]   i_cfg_data
);

    // widths, from the component width, fraction bits, coefficient and rest widths
    localparam int W      = sdf_pkg::COMP_W;
    localparam int F      = FRAC_BITS;
    localparam int K1_W   = sdf_pkg::COEF_W + 1;        // unsigned coef as signed
    localparam int L_W    = W + 1;                      // separation / dv component
    localparam int LEN2_W = 2 * W + 2;                  // squared length
    localparam int H      = W + 1;                      // root bits = sqrt stages
    localparam int LEN_W  = W + 1;
    localparam int DOT_W  = 2 * W + 3;
    localparam int Q      = W + F + 2;                  // quotient bits
    localparam int N      = DOT_W + F;                  // dividend width
    localparam int PROJ_W = Q + 1;
    localparam int U_W    = F + 2;                      // |unit component| <= 1.0
    localparam int DIFF_W = ((LEN_W > sdf_pkg::REST_W) ? LEN_W : sdf_pkg::REST_W) + 1;
    localparam int SP_W   = K1_W + DIFF_W;
    localparam int DP_W   = K1_W + PROJ_W;
    localparam int SUM_W  = ((SP_W > DP_W) ? SP_W : DP_W) + 1;
    localparam int C_W    = SUM_W - F + 1;
    localparam int M_W    = C_W + U_W;
    localparam int F1_W   = M_W - F;
    localparam int G_W    = F1_W + K1_W;
    localparam int G1_W   = G_W - F;
    localparam int P_W    = G1_W + K1_W;
    localparam int P1_W   = P_W - F;
    localparam int TAG_W  = $bits(sdf_pkg::t_side) + LEN_W;

    localparam logic signed [P1_W:0] SAT_HI = (P1_W+1)'((2 ** (W - 1)) - 1);
    localparam logic signed [P1_W:0] SAT_LO = ~SAT_HI;

    // whole pipeline advances unless the output word is held
    logic en;
    logic r_ov;
    assign en          = ~(r_ov & i_stall);
    assign o_stall     = r_ov & i_stall;
    assign o_valid     = r_ov;
    assign o_cfg_ready = 1'b1;

    // config registers
    logic [sdf_pkg::COEF_W-1:0] r_mass;
    logic [sdf_pkg::COEF_W-1:0] r_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= sdf_pkg::MASS_RESET;
            r_amp  <= sdf_pkg::AMP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdf_pkg::CFG_MASS_SCALE: r_mass <= i_cfg_data;
                sdf_pkg::CFG_AMPLITUDE:  r_amp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: separation and relative velocity
    // ------------------------------------------------------------------
    logic                     r1_v;
    logic [2:0][L_W-1:0]      r1_l;
    logic [2:0][L_W-1:0]      r1_dv;
    sdf_pkg::t_side           r1_side;
    logic [2:0][L_W-1:0]      n1_l;
    logic [2:0][L_W-1:0]      n1_dv;

    genvar gi, gk;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_diff
            assign n1_l[gi]  = L_W'($signed(i_a_position[gi*W +: W]))
                             - L_W'($signed(i_b_position[gi*W +: W]));
            assign n1_dv[gi] = L_W'($signed(i_a_velocity[gi*W +: W]))
                             - L_W'($signed(i_b_velocity[gi*W +: W]));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_l           <= n1_l;
            r1_dv          <= n1_dv;
            r1_side.stiff  <= i_stiffness;
            r1_side.damp   <= i_damping;
            r1_side.rest   <= i_rest_length;
            r1_side.a_pin  <= i_a_pinned;
            r1_side.b_pin  <= i_b_pinned;
            r1_side.zero   <= 1'b0;
            r1_side.a_slot <= sdf_pkg::SLOT_W'(i_a_index % sdf_pkg::SLOT_COUNT);
            r1_side.b_slot <= sdf_pkg::SLOT_W'(i_b_index % sdf_pkg::SLOT_COUNT);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: squares and dot-product terms
    // ------------------------------------------------------------------
    logic                           r2_v;
    logic signed [2*L_W-1:0]        r2_sq [0:2];
    logic signed [2*L_W-1:0]        r2_pr [0:2];
    logic [2:0][L_W-1:0]            r2_l;
    sdf_pkg::t_side                 r2_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= $signed(r1_l[i]) * $signed(r1_l[i]);
                r2_pr[i] <= $signed(r1_dv[i]) * $signed(r1_l[i]);
            end
            r2_l    <= r1_l;
            r2_side <= r1_side;
        end
    end

    // ------------------------------------------------------------------
    // stage 3 (sqrt entry) and H root stages, one root bit per stage
    // ------------------------------------------------------------------
    logic                     r_qv    [0:H];
    logic [LEN2_W-1:0]        r_qn    [0:H];
    logic [LEN2_W-1:0]        r_qroot [0:H];
    logic signed [DOT_W-1:0]  r_qdot  [0:H];
    logic [2:0][L_W-1:0]      r_ql    [0:H];
    sdf_pkg::t_side           r_qside [0:H];

    logic [LEN2_W-1:0]        n_len2;
    logic signed [DOT_W-1:0]  n_dot;
    sdf_pkg::t_side           n_qside;

    assign n_len2 = LEN2_W'(r2_sq[0]) + LEN2_W'(r2_sq[1]) + LEN2_W'(r2_sq[2]);
    assign n_dot  = DOT_W'(r2_pr[0]) + DOT_W'(r2_pr[1]) + DOT_W'(r2_pr[2]);

    // coinciding ends flagged here, before the root
    always_comb begin
        n_qside      = r2_side;
        n_qside.zero = (n_len2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qn[0]    <= n_len2;
            r_qroot[0] <= '0;
            r_qdot[0]  <= n_dot;
            r_ql[0]    <= r2_l;
            r_qside[0] <= n_qside;
        end
    end

    generate
        for (gk = 0; gk < H; gk++) begin : g_sqrt
            localparam logic [LEN2_W-1:0] SQ_BIT = LEN2_W'(1) << (2 * (H - 1 - gk));
            logic [LEN2_W-1:0] n_t;
            logic              n_ge;
            assign n_t  = r_qroot[gk] + SQ_BIT;
            assign n_ge = (r_qn[gk] >= n_t);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_qn[gk+1]    <= n_ge ? (r_qn[gk] - n_t) : r_qn[gk];
                    r_qroot[gk+1] <= n_ge ? ((r_qroot[gk] >> 1) + SQ_BIT)
                                          : (r_qroot[gk] >> 1);
                    r_qdot[gk+1]  <= r_qdot[gk];
                    r_ql[gk+1]    <= r_ql[gk];
                    r_qside[gk+1] <= r_qside[gk];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // divider: lane 0 projection dv.l / len, lanes 1..3 unit vector l / len
    // dividends carry F extra fraction bits so quotients come out in Q.F
    // ------------------------------------------------------------------
    logic [3:0][N-1:0]     n_dvd;
    logic [3:0]            n_neg;
    logic [LEN_W-1:0]      n_len;
    logic [DOT_W-1:0]      n_adot;
    logic                  d_valid;
    logic [3:0][Q:0]       d_quot;
    logic [TAG_W-1:0]      d_tag;
    sdf_pkg::t_side        d_side;
    logic [LEN_W-1:0]      d_len;

    assign n_len    = LEN_W'(r_qroot[H]);
    assign n_adot   = r_qdot[H][DOT_W-1] ? DOT_W'(-r_qdot[H]) : DOT_W'(r_qdot[H]);
    assign n_dvd[0] = {n_adot, {F{1'b0}}};
    assign n_neg[0] = r_qdot[H][DOT_W-1];

    generate
        for (gi = 0; gi < 3; gi++) begin : g_unit_in
            logic [L_W-1:0] n_al;
            assign n_al        = r_ql[H][gi][L_W-1] ? (L_W'(0) - r_ql[H][gi])
                                                    : r_ql[H][gi];
            assign n_neg[gi+1] = r_ql[H][gi][L_W-1];
            assign n_dvd[gi+1] = N'({n_al, {F{1'b0}}});
        end
    endgenerate

    sdf_div #(
        .N     (N),
        .D     (LEN_W),
        .Q     (Q),
        .LANES (4),
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_qv[H]),
        .i_dividend (n_dvd),
        .i_neg      (n_neg),
        .i_divisor  (n_len),
        .i_tag      ({r_qside[H], n_len}),
        .o_valid    (d_valid),
        .o_quot     (d_quot),
        .o_tag      (d_tag)
    );

    assign {d_side, d_len} = d_tag;

    // ------------------------------------------------------------------
    // p4: spring and damping terms
    // ------------------------------------------------------------------
    logic                     r4_v;
    logic signed [SP_W-1:0]   r4_spring;
    logic signed [DP_W-1:0]   r4_damp;
    logic [2:0][U_W-1:0]      r4_u;
    sdf_pkg::t_side           r4_side;
    logic signed [DIFF_W-1:0] n_diff;

    assign n_diff = DIFF_W'($signed({1'b0, d_len})) - DIFF_W'($signed({1'b0, d_side.rest}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_spring <= $signed({1'b0, d_side.stiff}) * n_diff;
            r4_damp   <= $signed({1'b0, d_side.damp}) * $signed(d_quot[0]);
            for (int i = 0; i < 3; i++) r4_u[i] <= U_W'(d_quot[i+1]);
            r4_side   <= d_side;
        end
    end

    // ------------------------------------------------------------------
    // p5: c = -floor((spring + damp) / 2^F)
    // ------------------------------------------------------------------
    logic                     r5_v;
    logic signed [C_W-1:0]    r5_c;
    logic [2:0][U_W-1:0]      r5_u;
    sdf_pkg::t_side           r5_side;
    logic signed [SUM_W-1:0]  n_sum;

    assign n_sum = SUM_W'(r4_spring) + SUM_W'(r4_damp);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_c    <= C_W'(0) - C_W'(n_sum >>> F);
            r5_u    <= r4_u;
            r5_side <= r4_side;
        end
    end

    // ------------------------------------------------------------------
    // p6..p8: c * u, then mass scale, then amplitude, floor after each
    // ------------------------------------------------------------------
    logic                     r6_v, r7_v, r8_v;
    logic signed [M_W-1:0]    r6_m [0:2];
    logic signed [G_W-1:0]    r7_g [0:2];
    logic signed [P_W-1:0]    r8_h [0:2];
    sdf_pkg::t_side           r6_side, r7_side, r8_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_m[i] <= r5_c * $signed(r5_u[i]);
                r7_g[i] <= $signed(F1_W'(r6_m[i] >>> F)) * $signed({1'b0, r_mass});
                r8_h[i] <= $signed(G1_W'(r7_g[i] >>> F)) * $signed({1'b0, r_amp});
            end
            r6_side <= r5_side;
            r7_side <= r6_side;
            r8_side <= r7_side;
        end
    end

    // ------------------------------------------------------------------
    // output register: saturate, negate for end b, pin and zero masking
    // ------------------------------------------------------------------
    logic [sdf_pkg::VEC_W-1:0] n_fa;
    logic [sdf_pkg::VEC_W-1:0] n_fb;

    generate
        for (gi = 0; gi < 3; gi++) begin : g_sat
            logic signed [P1_W:0] n_f;
            logic signed [P1_W:0] n_nf;
            assign n_f  = (P1_W+1)'($signed(P1_W'(r8_h[gi] >>> F)));
            assign n_nf = (P1_W+1)'(0) - n_f;
            assign n_fa[gi*W +: W] = (n_f > SAT_HI)  ? W'(SAT_HI) :
                                     (n_f < SAT_LO)  ? W'(SAT_LO) : W'(n_f);
            assign n_fb[gi*W +: W] = (n_nf > SAT_HI) ? W'(SAT_HI) :
                                     (n_nf < SAT_LO) ? W'(SAT_LO) : W'(n_nf);
        end
    endgenerate

    logic [sdf_pkg::VEC_W-1:0] r_fa, r_fb;
    logic [sdf_pkg::SLOT_W-1:0] r_aslot, r_bslot;
    logic                       r_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fa    <= (r8_side.zero | r8_side.a_pin) ? '0 : n_fa;
            r_fb    <= (r8_side.zero | r8_side.b_pin) ? '0 : n_fb;
            r_aslot <= r8_side.a_slot;
            r_bslot <= r8_side.b_slot;
            r_zero  <= r8_side.zero;
        end
    end

    assign o_force_on_a  = r_fa;
    assign o_force_on_b  = r_fb;
    assign o_a_slot      = r_aslot;
    assign o_b_slot      = r_bslot;
    assign o_zero_length = r_zero;

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            for (int k = 0; k <= H; k++) r_qv[k] <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r_qv[0] <= r2_v;
            for (int k = 1; k <= H; k++) r_qv[k] <= r_qv[k-1];
            r4_v    <= d_valid;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r_ov    <= r8_v;
        end
    end

    // checks
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word waiting");

    a_zero_gives_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |-> (o_force_on_a == '0 && o_force_on_b == '0))
        else $error("zero-length spring produced a force");

    a_freeze_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_qv[H] == $past(r_qv[H]) && d_valid == $past(d_valid)))
        else $error("pipeline moved while output word was held");

endmodule

// ===== bench/spring_damper_force_top_tb.sv =====
// ----------------------------------------------------------------------------
// spring_damper_force_top_tb: self-checking bench of the spring force pipeline
// directed table then random springs, checked against an in-bench force model
// ----------------------------------------------------------------------------
module spring_damper_force_top_tb;

    localparam longint CMAX  = (64'sd1 <<< (sdf_pkg::COMP_W - 1)) - 1;
    localparam longint CMIN  = -CMAX - 1;
    localparam int     LIMIT = 600000;   // cycles, many times the slowest legal run
    localparam int     DRAIN = 90;       // margin beyond the pipeline depth

    typedef struct packed {
        logic [sdf_pkg::VEC_W-1:0]  a_pos;
        logic [sdf_pkg::VEC_W-1:0]  a_vel;
        logic [sdf_pkg::VEC_W-1:0]  b_pos;
        logic [sdf_pkg::VEC_W-1:0]  b_vel;
        logic                       a_pin;
        logic                       b_pin;
        logic [sdf_pkg::COEF_W-1:0] ks;
        logic [sdf_pkg::COEF_W-1:0] kd;
        logic [sdf_pkg::REST_W-1:0] rest;
        logic [sdf_pkg::SLOT_W-1:0] a_idx;
        logic [sdf_pkg::SLOT_W-1:0] b_idx;
    } t_spring;

    typedef struct packed {
        logic [sdf_pkg::VEC_W-1:0]  fa;
        logic [sdf_pkg::VEC_W-1:0]  fb;
        logic [sdf_pkg::SLOT_W-1:0] a_slot;
        logic [sdf_pkg::SLOT_W-1:0] b_slot;
        logic                       zero;
    } t_force;

    // one directed row: typed marks a row whose expected word is written out
    typedef struct {
        t_spring s;
        bit      typed;
        t_force  f;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    t_spring                       drv;
    logic                          o_valid;
    logic                          i_stall;
    logic [sdf_pkg::VEC_W-1:0]     o_force_on_a;
    logic [sdf_pkg::VEC_W-1:0]     o_force_on_b;
    logic [sdf_pkg::SLOT_W-1:0]    o_a_slot;
    logic [sdf_pkg::SLOT_W-1:0]    o_b_slot;
    logic                          o_zero_length;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [sdf_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sdf_pkg::COEF_W-1:0]    i_cfg_data;

    spring_damper_force_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_a_position  (drv.a_pos),
        .i_a_velocity  (drv.a_vel),
        .i_b_position  (drv.b_pos),
        .i_b_velocity  (drv.b_vel),
        .i_a_pinned    (drv.a_pin),
        .i_b_pinned    (drv.b_pin),
        .i_stiffness   (drv.ks),
        .i_damping     (drv.kd),
        .i_rest_length (drv.rest),
        .i_a_index     (drv.a_idx),
        .i_b_index     (drv.b_idx),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_force_on_a  (o_force_on_a),
        .o_force_on_b  (o_force_on_b),
        .o_a_slot      (o_a_slot),
        .o_b_slot      (o_b_slot),
        .o_zero_length (o_zero_length),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // model copy of the two scale registers
    longint mass_q412;
    longint amp_q412;

    t_force pending_forces[$];
    int     mismatches;
    int     cycles;
    bit     quiet;           // no idling on either side in the closing phase

    // ------------------------------------------------------------------ clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ----------------------------------------------------------- force model
    function automatic longint comp_of(logic [sdf_pkg::VEC_W-1:0] v, int i);
        logic signed [sdf_pkg::COMP_W-1:0] c;
        c = v[i*sdf_pkg::COMP_W +: sdf_pkg::COMP_W];
        return longint'(c);
    endfunction

    function automatic longint clamp_comp(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    // floor of the square root, bit by bit from the top
    function automatic longint root_floor(longint n);
        longint r;
        r = 0;
        for (int b = 23; b >= 0; b--)
            if ((r | (64'sd1 <<< b)) * (r | (64'sd1 <<< b)) <= n) r = r | (64'sd1 <<< b);
        return r;
    endfunction

    function automatic t_force compute_force(t_spring s);
        longint l[3];
        longint dv[3];
        longint len2, dot, len, hooke, proj, c, u, f;
        t_force r;
        len2 = 0;
        dot  = 0;
        r    = '0;
        for (int i = 0; i < 3; i++) begin
            l[i]  = comp_of(s.a_pos, i) - comp_of(s.b_pos, i);
            dv[i] = comp_of(s.a_vel, i) - comp_of(s.b_vel, i);
            len2 += l[i] * l[i];
            dot  += dv[i] * l[i];
        end
        r.zero = (len2 == 0);
        if (!r.zero) begin
            len   = root_floor(len2);
            hooke = longint'(s.ks) * (len - longint'(s.rest));
            proj  = (dot * (64'sd1 <<< sdf_pkg::FRAC_BITS)) / len;  // truncates toward zero
            c     = -((hooke + longint'(s.kd) * proj) >>> sdf_pkg::FRAC_BITS);
            for (int i = 0; i < 3; i++) begin
                u = (l[i] * (64'sd1 <<< sdf_pkg::FRAC_BITS)) / len;
                f = (c * u) >>> sdf_pkg::FRAC_BITS;                  // arithmetic shift floors
                f = (f * mass_q412) >>> sdf_pkg::FRAC_BITS;
                f = (f * amp_q412) >>> sdf_pkg::FRAC_BITS;
                r.fa[i*sdf_pkg::COMP_W +: sdf_pkg::COMP_W] = sdf_pkg::COMP_W'(clamp_comp(f));
                r.fb[i*sdf_pkg::COMP_W +: sdf_pkg::COMP_W] = sdf_pkg::COMP_W'(clamp_comp(-f));
            end
        end
        if (s.a_pin) r.fa = '0;
        if (s.b_pin) r.fb = '0;
        r.a_slot = sdf_pkg::SLOT_W'(s.a_idx % sdf_pkg::SLOT_COUNT);
        r.b_slot = sdf_pkg::SLOT_W'(s.b_idx % sdf_pkg::SLOT_COUNT);
        return r;
    endfunction

    // -------------------------------------------------------- stimulus shapes
    function automatic logic [sdf_pkg::VEC_W-1:0] vec3(longint x, longint y, longint z);
        logic [sdf_pkg::VEC_W-1:0] v;
        v[0 +: sdf_pkg::COMP_W]                = sdf_pkg::COMP_W'(x);
        v[sdf_pkg::COMP_W +: sdf_pkg::COMP_W]   = sdf_pkg::COMP_W'(y);
        v[2*sdf_pkg::COMP_W +: sdf_pkg::COMP_W] = sdf_pkg::COMP_W'(z);
        return v;
    endfunction

    function automatic longint pick_comp();
        case ($urandom_range(0, 5))
            0:       return CMAX;
            1:       return CMIN;
            2:       return 0;
            3:       return longint'($urandom_range(0, 8000)) - 4000;
            default: return comp_of(sdf_pkg::VEC_W'({$urandom, $urandom}), 0);
        endcase
    endfunction

    function automatic logic [sdf_pkg::VEC_W-1:0] pick_vec();
        if ($urandom_range(0, 3) == 0) return sdf_pkg::VEC_W'({$urandom, $urandom});
        return vec3(pick_comp(), pick_comp(), pick_comp());
    endfunction

    // mostly a plausible spring: b near a, rest near the length; the rest is noise
    function automatic t_spring pick_spring();
        t_spring s;
        int      spread;
        s.a_pos = pick_vec();
        s.a_vel = pick_vec();
        s.b_vel = pick_vec();
        s.ks    = sdf_pkg::COEF_W'($urandom);
        s.kd    = sdf_pkg::COEF_W'($urandom);
        s.rest  = sdf_pkg::REST_W'($urandom);
        s.a_pin = ($urandom_range(0, 7) == 0);
        s.b_pin = ($urandom_range(0, 7) == 0);
        s.a_idx = sdf_pkg::SLOT_W'($urandom);
        s.b_idx = sdf_pkg::SLOT_W'($urandom);
        case ($urandom_range(0, 19))
            0: s.b_pos = s.a_pos;                          // coinciding ends
            1, 2, 3, 4, 5: s.b_pos = pick_vec();
            default: begin
                spread  = 1 << $urandom_range(2, 15);
                s.b_pos = vec3(
                    comp_of(s.a_pos, 0) + $urandom_range(0, 2*spread) - spread,
                    comp_of(s.a_pos, 1) + $urandom_range(0, 2*spread) - spread,
                    comp_of(s.a_pos, 2) + $urandom_range(0, 2*spread) - spread);
                s.rest  = sdf_pkg::REST_W'($urandom_range(0, 2*spread));
                if ($urandom_range(0, 1)) begin
                    s.ks = sdf_pkg::COEF_W'($urandom_range(0, 8192));
                    s.kd = sdf_pkg::COEF_W'($urandom_range(0, 2048));
                end
            end
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------- driving
    // word presented at the falling edge, held until taken at a rising edge
    task automatic put_word(t_spring s, bit typed, t_force f);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv     = s;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_forces.push_back(typed ? f : compute_force(s));
        @(negedge i_clk);
    endtask

    task automatic write_reg(sdf_pkg::t_cfg_idx idx, logic [sdf_pkg::COEF_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == sdf_pkg::CFG_MASS_SCALE) mass_q412 = longint'(val);
        else                                amp_q412  = longint'(val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // pipeline empty: every word back plus a margin for the depth
    task automatic drain();
        i_valid = 1'b0;
        while (pending_forces.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // ------------------------------------------------------ output stall bursts
    int stall_left;
    int run_left;
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            i_stall  <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            i_stall    <= 1'b1;
        end else begin
            run_left <= $urandom_range(1, 60);
            i_stall  <= 1'b0;
        end
    end

    // ----------------------------------------------------------- result check
    always @(posedge i_clk) begin
        t_force got;
        t_force want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_force_on_a, o_force_on_b, o_a_slot, o_b_slot, o_zero_length};
            if (pending_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: fa=%h fb=%h", got.fa, got.fb);
            end else begin
                want = pending_forces.pop_front();
                if (got.fa !== want.fa || got.fb !== want.fb || got.a_slot !== want.a_slot
                    || got.b_slot !== want.b_slot || got.zero !== want.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: fa %h/%h fb %h/%h slots %h,%h/%h,%h zero %b/%b",
                                 want.fa, got.fa, want.fb, got.fb, want.a_slot, want.b_slot,
                                 got.a_slot, got.b_slot, want.zero, got.zero);
                end
            end
        end
    end

    // ---------------------------------------------------------------- timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // --------------------------------------------------------------- sequence
    initial begin
        t_row   rows[$];
        t_row   r;
        t_force none;
        longint mass_set[6];
        longint amp_set[6];

        quiet       = 1'b0;
        mass_q412   = longint'(sdf_pkg::MASS_RESET);
        amp_q412    = longint'(sdf_pkg::AMP_RESET);
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = sdf_pkg::CFG_MASS_SCALE;
        i_cfg_data  = '0;
        drv         = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        none = '0;
        // coinciding ends, both forces zero and the flag up
        r.s = '{vec3(100, -200, 300), vec3(5, 6, 7), vec3(100, -200, 300), vec3(0, 0, 0),
                1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 20'd4096, 12'd1, 12'd2};
        r.typed = 1'b1; r.f = '{'0, '0, 12'd1, 12'd2, 1'b1}; rows.push_back(r);
        // coinciding ends, pinned too
        r.s.a_pin = 1'b1; r.s.b_pin = 1'b1; r.s.a_idx = 12'hFFF; r.s.b_idx = 12'h000;
        r.f = '{'0, '0, 12'hFFF, 12'h000, 1'b1}; rows.push_back(r);
        // both ends pinned apart: zero forces, no flag
        r.s.b_pos = vec3(0, 0, 0);
        r.f = '{'0, '0, 12'hFFF, 12'h000, 1'b0}; rows.push_back(r);
        // no stiffness, no damping: zero force
        r.s.a_pin = 1'b0; r.s.b_pin = 1'b0; r.s.ks = '0; r.s.kd = '0;
        r.f = '{'0, '0, 12'hFFF, 12'h000, 1'b0}; rows.push_back(r);
        r.typed = 1'b0; r.f = none;
        // extreme separation both ways, heavy constants, saturation
        r.s = '{vec3(CMAX, CMAX, CMAX), vec3(CMIN, CMIN, CMIN), vec3(CMIN, CMIN, CMIN),
                vec3(CMAX, CMAX, CMAX), 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                12'hAAA, 12'h555};
        rows.push_back(r);
        r.s.a_pos = vec3(CMIN, CMIN, CMIN); r.s.b_pos = vec3(CMAX, CMAX, CMAX);
        r.s.rest = '0; rows.push_back(r);
        // one end pinned at a time
        r.s.a_pin = 1'b1; rows.push_back(r);
        r.s.a_pin = 1'b0; r.s.b_pin = 1'b1; rows.push_back(r);
        // stretched unit spring along x, compressed along y, damping only along z
        r.s = '{vec3(8192, 0, 0), '0, '0, '0, 1'b0, 1'b0, 16'd4096, 16'd0, 20'd4096,
                12'd3, 12'd4};
        rows.push_back(r);
        r.s.a_pos = vec3(0, 2048, 0); rows.push_back(r);
        r.s.a_pos = vec3(0, 0, -4096); r.s.a_vel = vec3(0, 0, 4096); r.s.ks = '0;
        r.s.kd = 16'd4096; rows.push_back(r);
        // smallest nonzero separation
        r.s = '{vec3(1, 0, 0), vec3(CMAX, 0, 0), '0, vec3(CMIN, 0, 0), 1'b0, 1'b0,
                16'hFFFF, 16'hFFFF, 20'd0, 12'hFFF, 12'hFFF};
        rows.push_back(r);
        foreach (rows[k]) put_word(rows[k].s, rows[k].typed, rows[k].f);
        drain();

        // random phases, each under its own register setting
        mass_set = '{4096, 65535, 0,    8192, 1,     4096};
        amp_set  = '{4096, 65535, 1234, 2048, 65535, 4096};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                write_reg(sdf_pkg::CFG_MASS_SCALE,
                          sdf_pkg::COEF_W'((ph == 4) ? longint'($urandom) : mass_set[ph]));
                write_reg(sdf_pkg::CFG_AMPLITUDE, sdf_pkg::COEF_W'(amp_set[ph]));
            end
            quiet = (ph == 5);
            for (int n = 0; n < 240; n++) put_word(pick_spring(), 1'b0, none);
            // sender holds off here until every word is back
            drain();
        end

        if (mismatches == 0 && pending_forces.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/sdf_pkg.sv
src/sdf_div.sv
src/spring_damper_force_top.sv
bench/spring_damper_force_top_tb.sv
